// ----- sv/mpcbf_pkg.sv -----
// Shared constants and item types for the mouse packet check and byte FIFO block.
`timescale 1ns / 1ps

package mpcbf_pkg;

    // Byte store depth and derived widths
    localparam int STORE_DEPTH = 128;
    localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int PKT_LEN     = 3;

    // Operation codes
    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Status byte check bits
    localparam int BIT_ALWAYS_ONE = 3;
    localparam int BIT_X_OVF      = 6;
    localparam int BIT_Y_OVF      = 7;

    typedef struct packed {
        logic       operation;
        logic [7:0] status_byte;
        logic [7:0] x_move;
        logic [7:0] y_move;
    } in_item_t;

    typedef struct packed {
        logic       packet_rejected;
        logic [1:0] bytes_stored;
        logic       read_ready;
        logic [7:0] out_byte0;
        logic [7:0] out_byte1;
        logic [7:0] out_byte2;
        logic [7:0] fill_level;
    } out_item_t;

    // Handshake between sequencer and output stage
    typedef struct packed {
        logic done;
        logic ack;
    } seq_hs_t;

endpackage

// ----- sv/mpcbf_byte_ram.sv -----
// Single-port byte memory with registered read data.
`timescale 1ns / 1ps

module mpcbf_byte_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/mpcbf_seq.sv -----
// Sequencer: packet check, pointer/count unit and byte-at-a-time memory access.
`timescale 1ns / 1ps

module mpcbf_seq (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  mpcbf_pkg::in_item_t      in_data,
    output mpcbf_pkg::out_item_t     result,
    input  logic                     out_ack,
    output logic                     done,
    output logic                     ram_we,
    output logic [mpcbf_pkg::IDX_W-1:0] ram_addr,
    output logic [7:0]               ram_wdata,
    input  logic [7:0]               ram_rdata
);
    import mpcbf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_POP,
        S_LAST,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       step_reg, step_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    in_item_t         item_reg, item_next;
    logic             rejected_reg, rejected_next;
    logic [1:0]       stored_reg, stored_next;
    logic             ready_reg, ready_next;
    logic [7:0]       b0_reg, b0_next;
    logic [7:0]       b1_reg, b1_next;
    logic [7:0]       b2_reg, b2_next;

    logic [IDX_W-1:0] ptr_sel;
    logic [IDX_W-1:0] ptr_inc;
    logic             store_full;
    logic             bad_status;
    logic [CNT_W+7:0] fill_wide;

    // Shared pointer unit: advance with wrap
    assign ptr_sel    = (state_reg == S_PUSH) ? tail_reg : head_reg;
    assign ptr_inc    = (ptr_sel == IDX_W'(STORE_DEPTH - 1)) ? '0 : ptr_sel + 1'b1;
    assign store_full = (count_reg == CNT_W'(STORE_DEPTH));
    assign bad_status = in_data.status_byte[BIT_X_OVF] | in_data.status_byte[BIT_Y_OVF]
                      | ~in_data.status_byte[BIT_ALWAYS_ONE];
    assign fill_wide  = {8'b0, count_reg};

    // Memory port follows the current pointer
    assign ram_addr = ptr_sel;
    always_comb
    begin
        case (step_reg)
            2'd0:    ram_wdata = item_reg.status_byte;
            2'd1:    ram_wdata = item_reg.x_move;
            default: ram_wdata = item_reg.y_move;
        endcase
    end
    assign ram_we = (state_reg == S_PUSH) && !store_full;

    // Next state and datapath
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        item_next     = item_reg;
        rejected_next = rejected_reg;
        stored_next   = stored_reg;
        ready_next    = ready_reg;
        b0_next       = b0_reg;
        b1_next       = b1_reg;
        b2_next       = b2_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next     = in_data;
                    step_next     = 2'd0;
                    rejected_next = 1'b0;
                    stored_next   = 2'd0;
                    ready_next    = 1'b0;
                    b0_next       = 8'd0;
                    b1_next       = 8'd0;
                    b2_next       = 8'd0;
                    if (in_data.operation == OP_PACKET)
                    begin
                        if (bad_status)
                        begin
                            rejected_next = 1'b1;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            state_next = S_PUSH;
                        end
                    end
                    else
                    begin
                        if (count_reg >= CNT_W'(PKT_LEN))
                        begin
                            ready_next = 1'b1;
                            state_next = S_POP;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_PUSH:
            begin
                // Push one byte, drop it alone when full
                if (!store_full)
                begin
                    tail_next   = ptr_inc;
                    count_next  = count_reg + 1'b1;
                    stored_next = stored_reg + 2'd1;
                end
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    state_next = S_DONE;
                end
            end
            S_POP:
            begin
                // Issue one read, capture the previous one
                head_next  = ptr_inc;
                count_next = count_reg - 1'b1;
                step_next  = step_reg + 2'd1;
                case (step_reg)
                    2'd1:    b0_next = ram_rdata;
                    2'd2:    b1_next = ram_rdata;
                    default: ;
                endcase
                if (step_reg == 2'd2)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                b2_next    = ram_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, pointers and result fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 2'd0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        rejected_reg <= rejected_next;
        stored_reg   <= stored_next;
        ready_reg    <= ready_next;
        b0_reg       <= b0_next;
        b1_reg       <= b1_next;
        b2_reg       <= b2_next;
    end

    assign in_ready = (state_reg == S_IDLE);
    assign done     = (state_reg == S_DONE);

    always_comb
    begin
        result.packet_rejected = rejected_reg;
        result.bytes_stored    = stored_reg;
        result.read_ready      = ready_reg;
        result.out_byte0       = b0_reg;
        result.out_byte1       = b1_reg;
        result.out_byte2       = b2_reg;
        result.fill_level      = fill_wide[7:0];
    end

endmodule

// ----- sv/mouse_packet_check_and_byte_fifo.sv -----
// Top level: sequencer, byte memory and registered result stage.
// A rejected packet or an empty read goes straight to the done state; a
// stored packet or a successful read moves its bytes one per cycle through
// the single memory port. The sequencer takes no new item until its result
// has entered the output register. Reset clears pointers, count and valid;
// no clear pass.
`timescale 1ns / 1ps

module mouse_packet_check_and_byte_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mpcbf_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mpcbf_pkg::out_item_t out_data
);
    import mpcbf_pkg::*;

    seq_hs_t          hs;
    out_item_t        result;
    logic             ram_we;
    logic [IDX_W-1:0] ram_addr;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_rdata;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg;

    mpcbf_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .result    (result),
        .out_ack   (hs.ack),
        .done      (hs.done),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    mpcbf_byte_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Load the result when the output register is free or being drained
    assign hs.ack = hs.done && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (hs.ack)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hs.ack)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the mouse packet check and byte FIFO block.
`timescale 1ns / 1ps

module testbench;

    import mpcbf_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_e;

    // Track the byte store and hold the results it should produce, oldest first
    class fifo_tracker;
        logic [7:0] store_bytes [STORE_DEPTH];
        int         head;
        int         tail;
        int         count;
        out_item_t  pending_results [$];
        int         failures;

        function new();
            head     = 0;
            tail     = 0;
            count    = 0;
            failures = 0;
        endfunction

        function int push_byte(logic [7:0] b);
            if (count >= STORE_DEPTH)
                return 0;
            store_bytes[tail] = b;
            tail = (tail + 1 >= STORE_DEPTH) ? 0 : tail + 1;
            count++;
            return 1;
        endfunction

        function logic [7:0] pop_byte();
            logic [7:0] b;
            b = store_bytes[head];
            head = (head + 1 >= STORE_DEPTH) ? 0 : head + 1;
            count--;
            return b;
        endfunction

        // Work out the result of one accepted item and queue it
        function void note_item(in_item_t item);
            out_item_t res;
            int        pushed;
            res = '0;
            if (item.operation == OP_PACKET) begin
                if (item.status_byte[BIT_X_OVF] || item.status_byte[BIT_Y_OVF] ||
                    !item.status_byte[BIT_ALWAYS_ONE])
                begin
                    res.packet_rejected = 1'b1;
                end
                else
                begin
                    // Each byte is tried on its own when the store is full
                    pushed = push_byte(item.status_byte);
                    pushed += push_byte(item.x_move);
                    pushed += push_byte(item.y_move);
                    res.bytes_stored = 2'(pushed);
                end
            end
            else if (count >= PKT_LEN)
            begin
                res.read_ready = 1'b1;
                res.out_byte0  = pop_byte();
                res.out_byte1  = pop_byte();
                res.out_byte2  = pop_byte();
            end
            res.fill_level = 8'(count);
            pending_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
            if (act_val !== exp_val)
            begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_val, act_val);
                failures++;
            end
        endfunction

        // Compare one accepted result with the oldest queued one
        function void check_item(out_item_t got);
            out_item_t exp_res;
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result with none pending, actual %p", $time, got);
                failures++;
                return;
            end
            exp_res = pending_results.pop_front();
            compare_field("packet_rejected", 8'(exp_res.packet_rejected),
                          8'(got.packet_rejected));
            compare_field("bytes_stored", 8'(exp_res.bytes_stored), 8'(got.bytes_stored));
            compare_field("read_ready", 8'(exp_res.read_ready), 8'(got.read_ready));
            compare_field("out_byte0", exp_res.out_byte0, got.out_byte0);
            compare_field("out_byte1", exp_res.out_byte1, got.out_byte1);
            compare_field("out_byte2", exp_res.out_byte2, got.out_byte2);
            compare_field("fill_level", exp_res.fill_level, got.fill_level);
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    // Set while both sides run without idling
    bit        steady    = 1'b0;

    fifo_tracker tracker;

    mouse_packet_check_and_byte_fifo u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    // Stall the result side at random
    always @(negedge clk)
    begin
        out_ready <= steady || ($urandom_range(99) >= 24);
    end

    // Check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_item(out_data);
    end

    // End the run when nothing moves for too long
    initial
    begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic in_item_t make_item(logic op, logic [7:0] status);
        in_item_t item;
        item.operation   = op;
        item.status_byte = status;
        item.x_move      = 8'($urandom);
        item.y_move      = 8'($urandom);
        return item;
    endfunction

    function automatic logic [7:0] good_status();
        logic [7:0] s;
        s = 8'($urandom);
        s[BIT_X_OVF]      = 1'b0;
        s[BIT_Y_OVF]      = 1'b0;
        s[BIT_ALWAYS_ONE] = 1'b1;
        return s;
    endfunction

    // Break the status byte in one of the three ways the check looks for
    function automatic logic [7:0] broken_status();
        logic [7:0] s;
        s = 8'($urandom);
        case ($urandom_range(2))
            0:       s[BIT_ALWAYS_ONE] = 1'b0;
            1:       s[BIT_X_OVF]      = 1'b1;
            default: s[BIT_Y_OVF]      = 1'b1;
        endcase
        return s;
    endfunction

    // Offer one item, with an optional idle gap, and note it once accepted.
    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(in_item_t item);
        if (!steady && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < 30);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_item(item);
        @(negedge clk);
    endtask

    task automatic send_packet(logic [7:0] status, logic [7:0] x_val, logic [7:0] y_val);
        in_item_t item;
        item.operation   = OP_PACKET;
        item.status_byte = status;
        item.x_move      = x_val;
        item.y_move      = y_val;
        send_item(item);
    endtask

    task automatic run_directed();
        // Read on an empty store
        send_item(make_item(OP_READ, 8'($urandom)));
        // Reject on each failed check
        send_packet(8'h00, 8'h00, 8'h00);
        send_packet(8'hF7, 8'hFF, 8'hFF);
        send_packet(8'h48, 8'h12, 8'h34);
        send_packet(8'h88, 8'h56, 8'h78);
        send_packet(8'hFF, 8'hFF, 8'hFF);
        // Store and read back the smallest and largest good packets
        send_packet(8'h08, 8'h00, 8'h00);
        send_item(make_item(OP_READ, 8'h00));
        send_item(make_item(OP_READ, 8'hFF));
        send_packet(8'h3F, 8'hFF, 8'hFF);
        send_packet(8'h08, 8'hFF, 8'h00);
        send_item(make_item(OP_READ, 8'($urandom)));
        send_item(make_item(OP_READ, 8'($urandom)));
        send_item(make_item(OP_READ, 8'($urandom)));
    endtask

    // Bursts that fill, drain or mix, so the store reaches full and empty often
    task automatic run_random();
        int            sent;
        int            burst_len;
        int            read_pct;
        traffic_mode_e mode;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mode      = (sent == 0) ? MODE_FILL : traffic_mode_e'($urandom_range(2));
            burst_len = $urandom_range(20, 90);
            case (mode)
                MODE_FILL:  read_pct = 5;
                MODE_DRAIN: read_pct = 85;
                default:    read_pct = 45;
            endcase
            for (int k = 0; k < burst_len && sent < RANDOM_ITEMS; k++)
            begin
                steady = (sent >= 250 && sent < 350);
                if ($urandom_range(99) < read_pct)
                    send_item(make_item(OP_READ, 8'($urandom)));
                else if ($urandom_range(99) < 85)
                    send_item(make_item(OP_PACKET, good_status()));
                else
                    send_item(make_item(OP_PACKET, broken_status()));
                sent++;
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        tracker = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        run_directed();
        run_random();
        in_valid <= 1'b0;
        // Let every queued result arrive, then watch a little longer
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.failures == 0 && tracker.pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
